FILE: rtl/ps2mc_pkg.sv
// Package for the PS/2 wheel-mouse packet decoder.
// Holds the header bit masks, the wheel codes, register indexes and the byte slot type.
// No dependencies.
package ps2mc_pkg;

  localparam int CoordBits = 10;
  localparam int CfgIdxBits = 2;

  localparam logic [7:0] HDR_OVERFLOW = 8'hc0;
  localparam logic [7:0] HDR_ALWAYS1  = 8'h08;
  localparam logic [7:0] HDR_BUTTONS  = 8'h07;
  localparam int         HDR_XSIGN_BIT = 4;
  localparam int         HDR_YSIGN_BIT = 5;

  localparam logic [7:0] WHEEL_UP_CODE   = 8'hff;
  localparam logic [7:0] WHEEL_DOWN_CODE = 8'h01;

  localparam logic [CfgIdxBits-1:0] REG_X_LIMIT = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_Y_LIMIT = 2'd1;

  localparam logic [CoordBits-1:0] X_LIMIT_RESET = 10'd319;
  localparam logic [CoordBits-1:0] Y_LIMIT_RESET = 10'd199;
  localparam int                   POS_X_RESET   = 160;
  localparam int                   POS_Y_RESET   = 100;

  typedef enum logic [1:0] {
    SLOT_HDR,
    SLOT_DX,
    SLOT_DY,
    SLOT_WHEEL
  } slot_t;

  typedef struct packed {
    logic [CoordBits-1:0] cursor_x;
    logic [CoordBits-1:0] cursor_y;
    logic                 wheel_up;
    logic                 wheel_down;
  } cursor_beat_t;

endpackage

FILE: rtl/ps2mc_byte_if.sv
// Stream channel for received mouse bytes.
// Depends on nothing.
interface ps2mc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/ps2mc_cursor_if.sv
// Stream channel for cursor results.
// Depends on nothing.
interface ps2mc_cursor_if;
  logic       valid;
  logic       ready;
  logic [9:0] cursor_x;
  logic [9:0] cursor_y;
  logic       wheel_up;
  logic       wheel_down;

  modport source (output valid, output cursor_x, output cursor_y, output wheel_up,
                  output wheel_down, input ready);
  modport sink (input valid, input cursor_x, input cursor_y, input wheel_up,
                input wheel_down, output ready);
endinterface

FILE: rtl/ps2mc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on nothing.
interface ps2mc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/ps2_mouse_packet_cursor.sv
// Top level of the PS/2 wheel-mouse packet decoder with clamped cursor.
// Uses ps2mc_pkg and the ps2mc_byte_if, ps2mc_cursor_if, ps2mc_cfg_if interfaces.
// A result is registered in the cycle after the wheel byte is accepted when the
// output register is free; otherwise it waits in the skid entry until taken.
// Throughput: one byte per cycle; results sit in an output register and a
// one-entry skid, and input stalls only while the skid entry is occupied.
// Reset (rst, synchronous): waits for a header, cursor at 160/100, limits 319/199.
module ps2_mouse_packet_cursor
  import ps2mc_pkg::*;
#(
  parameter int POSITION_BITS = 10
) (
  input  logic           clk,
  input  logic           rst,
  ps2mc_byte_if.sink     rx,
  ps2mc_cursor_if.source cur,
  ps2mc_cfg_if.sink      cfg
);

  localparam int P  = POSITION_BITS;
  localparam int LW = (P > CoordBits) ? P : CoordBits;
  localparam logic [LW-1:0] MAXPOS = LW'((1 << P) - 1);

  logic [CoordBits-1:0] x_limit, y_limit;
  slot_t                byte_slot, byte_slot_next;
  logic [7:0]           header_store, dx_store, dy_store;
  logic [P-1:0]         pos_x, pos_y, pos_x_next, pos_y_next;

  logic         o_valid, s_valid;
  cursor_beat_t o_data, s_data, r_data;

  logic rx_fire, out_take, hdr_ok, r_valid;

  logic [LW-1:0]      xlim_sat, ylim_sat;
  logic signed [P+1:0] nx, ny, xlim_s, ylim_s;
  logic [LW-1:0]      px_ext, py_ext;

  assign rx.ready  = !s_valid;
  assign cfg.ready = 1'b1;
  assign rx_fire   = rx.valid && rx.ready;
  assign out_take  = cur.valid && cur.ready;

  assign hdr_ok = ((rx.rx_byte & HDR_OVERFLOW) == 8'h00) &&
                  ((rx.rx_byte & HDR_ALWAYS1) != 8'h00) &&
                  ((rx.rx_byte & HDR_BUTTONS) == 8'h00);

  // next slot
  always_comb begin
    byte_slot_next = byte_slot;
    if (rx_fire) begin
      case (byte_slot)
        SLOT_HDR:   byte_slot_next = hdr_ok ? SLOT_DX : SLOT_HDR;
        SLOT_DX:    byte_slot_next = SLOT_DY;
        SLOT_DY:    byte_slot_next = SLOT_WHEEL;
        SLOT_WHEEL: byte_slot_next = SLOT_HDR;
        default:    byte_slot_next = SLOT_HDR;
      endcase
    end
  end

  // position update
  always_comb begin
    xlim_sat = (LW'(x_limit) > MAXPOS) ? MAXPOS : LW'(x_limit);
    ylim_sat = (LW'(y_limit) > MAXPOS) ? MAXPOS : LW'(y_limit);
    xlim_s   = $signed({2'b00, xlim_sat[P-1:0]});
    ylim_s   = $signed({2'b00, ylim_sat[P-1:0]});
    nx = $signed({2'b00, pos_x}) +
         $signed({{(P-6){header_store[HDR_XSIGN_BIT]}}, dx_store});
    ny = $signed({2'b00, pos_y}) -
         $signed({{(P-6){header_store[HDR_YSIGN_BIT]}}, dy_store});
    if (nx < 0)           pos_x_next = '0;
    else if (nx > xlim_s) pos_x_next = xlim_sat[P-1:0];
    else                  pos_x_next = nx[P-1:0];
    if (ny < 0)           pos_y_next = '0;
    else if (ny > ylim_s) pos_y_next = ylim_sat[P-1:0];
    else                  pos_y_next = ny[P-1:0];
  end

  // result outputs
  always_comb begin
    r_valid = rx_fire && (byte_slot == SLOT_WHEEL);
    px_ext  = LW'(pos_x_next);
    py_ext  = LW'(pos_y_next);
    r_data.cursor_x   = px_ext[CoordBits-1:0];
    r_data.cursor_y   = py_ext[CoordBits-1:0];
    r_data.wheel_up   = (rx.rx_byte == WHEEL_UP_CODE);
    r_data.wheel_down = (rx.rx_byte == WHEEL_DOWN_CODE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit   <= X_LIMIT_RESET;
      y_limit   <= Y_LIMIT_RESET;
      byte_slot <= SLOT_HDR;
      pos_x     <= P'(POS_X_RESET);
      pos_y     <= P'(POS_Y_RESET);
      o_valid   <= 1'b0;
      s_valid   <= 1'b0;
    end else begin
      byte_slot <= byte_slot_next;
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_X_LIMIT) x_limit <= cfg.data;
        else if (cfg.index == REG_Y_LIMIT) y_limit <= cfg.data;
      end
      if (r_valid) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
      end
      if (!o_valid || out_take) begin
        if (s_valid) begin
          o_valid <= 1'b1;
          s_valid <= r_valid;
        end else begin
          o_valid <= r_valid;
        end
      end else if (r_valid) begin
        s_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire) begin
      if (byte_slot == SLOT_HDR) header_store <= rx.rx_byte;
      if (byte_slot == SLOT_DX)  dx_store     <= rx.rx_byte;
      if (byte_slot == SLOT_DY)  dy_store     <= rx.rx_byte;
    end
    if (!o_valid || out_take) begin
      if (s_valid) begin
        o_data <= s_data;
        if (r_valid) s_data <= r_data;
      end else if (r_valid) begin
        o_data <= r_data;
      end
    end else if (r_valid) begin
      s_data <= r_data;
    end
  end

  assign cur.valid      = o_valid;
  assign cur.cursor_x   = o_data.cursor_x;
  assign cur.cursor_y   = o_data.cursor_y;
  assign cur.wheel_up   = o_data.wheel_up;
  assign cur.wheel_down = o_data.wheel_down;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> o_valid)
    else $error("skid entry held with empty output register");

  a_bad_header_dropped: assert property (@(posedge clk) disable iff (rst)
    (rx_fire && byte_slot == SLOT_HDR && !hdr_ok) |=> (byte_slot == SLOT_HDR))
    else $error("bad header advanced the byte slot");

  a_wheel_ends_packet: assert property (@(posedge clk) disable iff (rst)
    (rx_fire && byte_slot == SLOT_WHEEL) |=> (byte_slot == SLOT_HDR && o_valid))
    else $error("wheel byte did not close the packet with a result");

  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    (!o_valid && !(rx_fire && byte_slot == SLOT_WHEEL)) |=> !o_valid)
    else $error("result appeared without a wheel byte");

endmodule
